### rtl/core/bfra_pkg.sv
`timescale 1ns / 1ps
// shared types, sizes and status codes of the best-fit region allocator
// no dependencies

package bfra_pkg;

    localparam int MEM_SIZE      = 1024;
    localparam int FREE_ENTRIES  = 16;
    localparam int OWNED_ENTRIES = 16;

    localparam int ADDR_W   = $clog2(MEM_SIZE);
    localparam int JOB_W    = 8;
    localparam int SIZE_W   = 11;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = ADDR_W + 1;
    localparam int CMP_W    = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;

    localparam int FIDX_W = $clog2(FREE_ENTRIES);
    localparam int FCNT_W = $clog2(FREE_ENTRIES + 1);
    localparam int OIDX_W = $clog2(OWNED_ENTRIES);
    localparam int OCNT_W = $clog2(OWNED_ENTRIES + 1);
    localparam int IDX_W  = (FIDX_W > OIDX_W) ? FIDX_W : OIDX_W;
    localparam int CNT_W  = (FCNT_W > OCNT_W) ? FCNT_W : OCNT_W;

    localparam logic [SIZE_W-1:0] MIN_LEFTOVER_RST = SIZE_W'(10);

    localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_NOFIT = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_NOJOB = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] ST_ZERO  = STATUS_W'(4);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
    } free_word_t;

    typedef struct packed {
        logic [JOB_W-1:0]  owner;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
    } own_word_t;

    localparam int FREE_W = $bits(free_word_t);
    localparam int OWN_W  = $bits(own_word_t);

    typedef struct packed {
        logic             clear;
        logic             valid;
        logic             is_free;
        logic [IDX_W-1:0] idx;
    } scan_ctl_t;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
        logic [CMP_W-1:0]  len;
    } scan_res_t;

endpackage

### rtl/core/bfra_req_if.sv
`timescale 1ns / 1ps
// request channel: valid/ready handshake with kind, job id and size
// depends on bfra_pkg

interface bfra_req_if;
    import bfra_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [JOB_W-1:0]  job_id;
    logic [SIZE_W-1:0] request_size;

    modport source (output valid, output kind, output job_id, output request_size,
                    input ready);
    modport sink   (input valid, input kind, input job_id, input request_size,
                    output ready);
endinterface

### rtl/core/bfra_rsp_if.sv
`timescale 1ns / 1ps
// response channel: valid/ready handshake with status and region bounds
// depends on bfra_pkg

interface bfra_rsp_if;
    import bfra_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   region_start;
    logic [ADDR_W-1:0]   region_end;

    modport source (output valid, output status, output region_start, output region_end,
                    input ready);
    modport sink   (input valid, input status, input region_start, input region_end,
                    output ready);
endinterface

### rtl/core/bfra_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module bfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/bfra_scan.sv
`timescale 1ns / 1ps
// shared compare unit: best-fit search over free entries, job match over owned entries
// depends on bfra_pkg

module bfra_scan import bfra_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  scan_ctl_t         ctl,
    input  logic [JOB_W-1:0]  job_id,
    input  logic [SIZE_W-1:0] request_size,
    input  free_word_t        free_word,
    input  own_word_t         own_word,
    output scan_res_t         res
);

    logic              found_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [ADDR_W-1:0] first_reg;
    logic [ADDR_W-1:0] last_reg;
    logic [CMP_W-1:0]  len_reg;

    logic [CMP_W-1:0]  len;
    logic [ADDR_W-1:0] ent_first;
    logic [ADDR_W-1:0] ent_last;
    logic              hit;

    always_comb
    begin
        len = CMP_W'(free_word.last) - CMP_W'(free_word.first) + CMP_W'(1);
        if (ctl.is_free)
        begin
            ent_first = own_word.first;
            ent_last  = own_word.last;
            hit       = !found_reg && (own_word.owner == job_id);
        end
        else
        begin
            ent_first = free_word.first;
            ent_last  = free_word.last;
            hit       = (len >= CMP_W'(request_size)) && (!found_reg || (len < len_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.valid && hit)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.clear && ctl.valid && hit)
        begin
            idx_reg   <= ctl.idx;
            first_reg <= ent_first;
            last_reg  <= ent_last;
            len_reg   <= len;
        end
    end

    assign res.found = found_reg;
    assign res.idx   = idx_reg;
    assign res.first = first_reg;
    assign res.last  = last_reg;
    assign res.len   = len_reg;

endmodule

### rtl/core/best_fit_region_allocator.sv
`timescale 1ns / 1ps
// Best-fit region allocator over a 1024-unit region, with a 16-entry free table and a
// 16-entry owned table held in rams. One request is taken at a time: after the beat is
// taken, one compare unit scans the table one entry per cycle (the whole free table for
// allocate, the owned table up to the first match for free), then the tables are
// updated in S_WRITE, after an S_RDLAST read of the last table entry where needed.
// Zero-size and owned-table-full allocates skip the scan and go straight to S_DONE. A
// result beat waits in an output register while the next request is taken. After reset
// the S_INIT state writes the initial free extent before the first request is taken.
// min_leftover is written through cfg_we/cfg_wdata; the user must write it only while
// no request is in flight, the block itself does not enforce it.
// depends on bfra_pkg, bfra_req_if, bfra_rsp_if, bfra_ram, bfra_scan

module best_fit_region_allocator import bfra_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    bfra_req_if.sink          req,
    bfra_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_RDLAST = 3'd3;
    localparam logic [2:0] S_WRITE  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic                kind_reg, kind_next;
    logic [JOB_W-1:0]    job_reg, job_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [SIZE_W-1:0]   min_lo_reg;
    logic [FCNT_W-1:0]   free_cnt_reg, free_cnt_next;
    logic [OCNT_W-1:0]   own_cnt_reg, own_cnt_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                whole_reg, whole_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_start_reg, res_start_next;
    logic [ADDR_W-1:0]   res_end_reg, res_end_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   out_start_reg, out_start_next;
    logic [ADDR_W-1:0]   out_end_reg, out_end_next;

    logic                free_we;
    logic [FIDX_W-1:0]   free_waddr;
    free_word_t          free_wdata;
    logic [FIDX_W-1:0]   free_raddr;
    free_word_t          free_rdata;
    logic                own_we;
    logic [OIDX_W-1:0]   own_waddr;
    own_word_t           own_wdata;
    logic [OIDX_W-1:0]   own_raddr;
    own_word_t           own_rdata;

    scan_ctl_t           scan_ctl;
    scan_res_t           scan_res;

    logic [CNT_W-1:0]    scan_limit;
    logic                issue;
    logic [FCNT_W-1:0]   free_cnt_m1;
    logic [OCNT_W-1:0]   own_cnt_m1;
    logic [CMP_W-1:0]    sum_x;
    logic [CMP_W-1:0]    leftover;
    logic                whole;
    logic [ADDR_W-1:0]   alloc_last;

    bfra_ram #(
        .WIDTH (FREE_W),
        .DEPTH (FREE_ENTRIES)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    bfra_ram #(
        .WIDTH (OWN_W),
        .DEPTH (OWNED_ENTRIES)
    ) u_own_ram (
        .clk   (clk),
        .we    (own_we),
        .waddr (own_waddr),
        .wdata (own_wdata),
        .raddr (own_raddr),
        .rdata (own_rdata)
    );

    bfra_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (scan_ctl),
        .job_id       (job_reg),
        .request_size (size_reg),
        .free_word    (free_rdata),
        .own_word     (own_rdata),
        .res          (scan_res)
    );

    always_comb
    begin
        scan_limit  = kind_reg ? CNT_W'(own_cnt_reg) : CNT_W'(free_cnt_reg);
        issue       = (state_reg == S_SCAN) && (scan_idx_reg < scan_limit) &&
                      !((kind_reg == KIND_FREE) && scan_res.found);
        free_cnt_m1 = free_cnt_reg - FCNT_W'(1);
        own_cnt_m1  = own_cnt_reg - OCNT_W'(1);
        sum_x       = CMP_W'(scan_res.first) + CMP_W'(size_reg);
        alloc_last  = ADDR_W'(sum_x - CMP_W'(1));
        leftover    = scan_res.len - CMP_W'(size_reg);
        whole       = leftover <= CMP_W'(min_lo_reg);

        free_raddr = (state_reg == S_RDLAST) ? free_cnt_m1[FIDX_W-1:0]
                                             : scan_idx_reg[FIDX_W-1:0];
        own_raddr  = (state_reg == S_RDLAST) ? own_cnt_m1[OIDX_W-1:0]
                                             : scan_idx_reg[OIDX_W-1:0];

        scan_ctl.clear   = (state_reg == S_IDLE) && req.valid;
        scan_ctl.valid   = pend_reg && (state_reg == S_SCAN);
        scan_ctl.is_free = kind_reg;
        scan_ctl.idx     = pend_idx_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        job_next        = job_reg;
        size_next       = size_reg;
        free_cnt_next   = free_cnt_reg;
        own_cnt_next    = own_cnt_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        whole_next      = whole_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_end_next    = res_end_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;

        free_we          = 1'b0;
        free_waddr       = scan_res.idx[FIDX_W-1:0];
        free_wdata.first = ADDR_W'(0);
        free_wdata.last  = ADDR_W'(MEM_SIZE - 1);
        own_we           = 1'b0;
        own_waddr        = own_cnt_reg[OIDX_W-1:0];
        own_wdata        = own_rdata;

        case (state_reg)
            S_INIT:
            begin
                free_we    = 1'b1;
                free_waddr = FIDX_W'(0);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next      = req.kind;
                    job_next       = req.job_id;
                    size_next      = req.request_size;
                    scan_idx_next  = CNT_W'(0);
                    res_start_next = ADDR_W'(0);
                    res_end_next   = ADDR_W'(0);
                    if ((req.kind == KIND_ALLOC) && (req.request_size == SIZE_W'(0)))
                    begin
                        res_status_next = ST_ZERO;
                        state_next      = S_DONE;
                    end
                    else if ((req.kind == KIND_ALLOC) &&
                             (own_cnt_reg == OCNT_W'(OWNED_ENTRIES)))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    if (!scan_res.found)
                    begin
                        res_status_next = (kind_reg == KIND_FREE) ? ST_NOJOB : ST_NOFIT;
                        state_next      = S_DONE;
                    end
                    else if (kind_reg == KIND_FREE)
                    begin
                        if (free_cnt_reg == FCNT_W'(FREE_ENTRIES))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RDLAST;
                        end
                    end
                    else
                    begin
                        whole_next = whole;
                        state_next = whole ? S_RDLAST : S_WRITE;
                    end
                end
            end
            S_RDLAST:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                free_we         = 1'b1;
                own_we          = 1'b1;
                res_status_next = ST_OK;
                res_start_next  = scan_res.first;
                state_next      = S_DONE;
                if (kind_reg == KIND_FREE)
                begin
                    free_waddr     = free_cnt_reg[FIDX_W-1:0];
                    free_wdata     = '{first: scan_res.first, last: scan_res.last};
                    free_cnt_next  = free_cnt_reg + FCNT_W'(1);
                    own_waddr      = scan_res.idx[OIDX_W-1:0];
                    own_wdata      = own_rdata;
                    own_cnt_next   = own_cnt_m1;
                    res_end_next   = scan_res.last;
                end
                else
                begin
                    if (whole_reg)
                    begin
                        free_wdata    = free_rdata;
                        free_cnt_next = free_cnt_m1;
                    end
                    else
                    begin
                        free_wdata = '{first: sum_x[ADDR_W-1:0], last: scan_res.last};
                    end
                    own_wdata    = '{owner: job_reg, first: scan_res.first, last: alloc_last};
                    own_cnt_next = own_cnt_reg + OCNT_W'(1);
                    res_end_next = alloc_last;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = res_start_reg;
                    out_end_next    = res_end_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            min_lo_reg    <= MIN_LEFTOVER_RST;
            free_cnt_reg  <= FCNT_W'(1);
            own_cnt_reg   <= OCNT_W'(0);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_cnt_reg  <= free_cnt_next;
            own_cnt_reg   <= own_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                min_lo_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        job_reg        <= job_next;
        size_reg       <= size_next;
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= pend_idx_next;
        whole_reg      <= whole_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_end_reg    <= res_end_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.region_start = out_start_reg;
    assign rsp.region_end   = out_end_reg;

`ifndef SYNTHESIS
    a_free_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= FCNT_W'(FREE_ENTRIES))
        else $error("free table count out of range");

    a_own_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        own_cnt_reg <= OCNT_W'(OWNED_ENTRIES))
        else $error("owned table count out of range");

    a_alloc_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) && (kind_reg == KIND_ALLOC)
        |=> own_cnt_reg == ($past(own_cnt_reg) + OCNT_W'(1)))
        else $error("allocate did not add an owned entry");

    a_ok_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_OK) |-> rsp.region_start <= rsp.region_end)
        else $error("region start past region end");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_OK)
        |-> (rsp.region_start == ADDR_W'(0)) && (rsp.region_end == ADDR_W'(0)))
        else $error("error beat carries a region");
`endif

endmodule

### dv/tb_best_fit_region_allocator.sv
`timescale 1ns / 1ps
// self-checking bench for best_fit_region_allocator: directed and random requests,
// checked beat by beat against a table-level model of the allocator kept in the bench
// depends on bfra_pkg, bfra_req_if, bfra_rsp_if and the allocator rtl

module tb_best_fit_region_allocator;
    import bfra_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   first;
        logic [ADDR_W-1:0]   last;
    } region_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;

    bfra_req_if req_ch ();
    bfra_rsp_if rsp_ch ();

    best_fit_region_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // bench copy of the allocator tables
    logic [ADDR_W-1:0] hole_first [FREE_ENTRIES];
    logic [ADDR_W-1:0] hole_last  [FREE_ENTRIES];
    int                hole_count;
    logic [JOB_W-1:0]  lease_job   [OWNED_ENTRIES];
    logic [ADDR_W-1:0] lease_first [OWNED_ENTRIES];
    logic [ADDR_W-1:0] lease_last  [OWNED_ENTRIES];
    int                lease_count;
    logic [SIZE_W-1:0] leftover_limit;

    region_result_t pending_results [$];
    region_result_t got_beat;
    region_result_t want_beat;

    int mismatches  = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit steady      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic region_result_t apply_request(input logic kind,
                                                     input logic [JOB_W-1:0] job,
                                                     input logic [SIZE_W-1:0] size);
        region_result_t r;
        bit found;
        int best;
        int best_len;
        int len;
        int idx;
        r.status = ST_OK;
        r.first  = '0;
        r.last   = '0;
        if (kind == KIND_ALLOC)
        begin
            if (size == 0)
                r.status = ST_ZERO;
            else if (lease_count >= OWNED_ENTRIES)
                r.status = ST_FULL;
            else
            begin
                found    = 1'b0;
                best     = 0;
                best_len = 0;
                for (int i = 0; i < hole_count; i++)
                begin
                    len = int'(hole_last[i]) - int'(hole_first[i]) + 1;
                    if (len >= int'(size) && (!found || len < best_len))
                    begin
                        found    = 1'b1;
                        best     = i;
                        best_len = len;
                    end
                end
                if (!found)
                    r.status = ST_NOFIT;
                else
                begin
                    r.first = hole_first[best];
                    r.last  = ADDR_W'(int'(hole_first[best]) + int'(size) - 1);
                    if (best_len - int'(size) <= int'(leftover_limit))
                    begin
                        // whole block leaves the table, last entry fills the slot
                        hole_count--;
                        hole_first[best] = hole_first[hole_count];
                        hole_last[best]  = hole_last[hole_count];
                    end
                    else
                        hole_first[best] = ADDR_W'(int'(hole_first[best]) + int'(size));
                    lease_job[lease_count]   = job;
                    lease_first[lease_count] = r.first;
                    lease_last[lease_count]  = r.last;
                    lease_count++;
                end
            end
        end
        else
        begin
            r.status = ST_NOJOB;
            idx = -1;
            for (int i = 0; i < lease_count; i++)
                if (idx < 0 && lease_job[i] == job)
                    idx = i;
            if (idx >= 0)
            begin
                if (hole_count >= FREE_ENTRIES)
                    r.status = ST_FULL;
                else
                begin
                    r.status = ST_OK;
                    r.first  = lease_first[idx];
                    r.last   = lease_last[idx];
                    hole_first[hole_count] = r.first;
                    hole_last[hole_count]  = r.last;
                    hole_count++;
                    lease_count--;
                    lease_job[idx]   = lease_job[lease_count];
                    lease_first[idx] = lease_first[lease_count];
                    lease_last[idx]  = lease_last[lease_count];
                end
            end
        end
        return r;
    endfunction

    // valid stays high across back-to-back beats
    task automatic send_request(input logic kind, input logic [JOB_W-1:0] job,
                                input logic [SIZE_W-1:0] size);
        while (!steady && $urandom_range(0, 99) < 10)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= kind;
        req_ch.job_id       <= job;
        req_ch.request_size <= size;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(apply_request(kind, job, size));
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_leftover(input int value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= SIZE_W'(value);
        @(posedge clk);
        leftover_limit = SIZE_W'(value);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_random_items(input int count);
        int roll;
        int pick;
        int len;
        int trim;
        int cap;
        int size;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15 + 4 * lease_count)
            begin
                if (lease_count > 0 && $urandom_range(0, 9) < 8)
                    send_request(KIND_FREE, lease_job[$urandom_range(0, lease_count - 1)],
                                 SIZE_W'($urandom_range(0, 1024)));
                else
                    send_request(KIND_FREE, JOB_W'($urandom_range(0, 255)),
                                 SIZE_W'($urandom_range(0, 1024)));
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    size = 0;
                else if (roll < 8)
                    size = $urandom_range(512, 1024);
                else if (roll < 45 && hole_count > 0)
                begin
                    // size close to a free block so it gets taken whole or nearly so
                    pick = $urandom_range(0, hole_count - 1);
                    len  = int'(hole_last[pick]) - int'(hole_first[pick]) + 1;
                    cap  = int'(leftover_limit) + 2;
                    if (cap > len - 1)
                        cap = len - 1;
                    trim = $urandom_range(0, 1) ? 0 : $urandom_range(0, cap);
                    size = len - trim;
                end
                else
                    size = $urandom_range(1, 64);
                send_request(KIND_ALLOC, JOB_W'($urandom_range(0, 255)), SIZE_W'(size));
            end
        end
    endtask

    task automatic test_directed();
        send_request(KIND_ALLOC, 8'd0,   11'd0);
        send_request(KIND_FREE,  8'd255, 11'd0);
        send_request(KIND_ALLOC, 8'd255, 11'd1024);
        send_request(KIND_ALLOC, 8'd0,   11'd1);
        send_request(KIND_FREE,  8'd255, 11'd2047);
        send_request(KIND_ALLOC, 8'd1,   11'd500);
        send_request(KIND_ALLOC, 8'd2,   11'd513);
        send_request(KIND_ALLOC, 8'd3,   11'd1);
        send_request(KIND_ALLOC, 8'd4,   11'd1);
        send_request(KIND_FREE,  8'd2,   11'd0);
        send_request(KIND_FREE,  8'd1,   11'd0);
        send_request(KIND_ALLOC, 8'd5,   11'd400);
        send_request(KIND_FREE,  8'd3,   11'd0);
        send_request(KIND_ALLOC, 8'd6,   11'd1);
        send_request(KIND_FREE,  8'd6,   11'd0);
        send_request(KIND_FREE,  8'd5,   11'd0);
        send_request(KIND_FREE,  8'd5,   11'd0);
        send_request(KIND_ALLOC, 8'd170, 11'd1023);
    endtask

    task automatic test_fill_tables();
        int tries;
        write_leftover(0);
        tries = 0;
        while (lease_count < OWNED_ENTRIES && tries < 40)
        begin
            send_request(KIND_ALLOC, JOB_W'($urandom_range(0, 255)),
                         SIZE_W'($urandom_range(1, 40)));
            tries++;
        end
        // owned table full
        send_request(KIND_ALLOC, JOB_W'($urandom_range(0, 255)), SIZE_W'($urandom_range(1, 40)));
        tries = 0;
        while (hole_count < FREE_ENTRIES && lease_count > 0 && tries < 40)
        begin
            send_request(KIND_FREE, lease_job[$urandom_range(0, lease_count - 1)],
                         SIZE_W'($urandom_range(0, 1024)));
            tries++;
        end
        // free table full
        if (lease_count > 0)
            send_request(KIND_FREE, lease_job[0], SIZE_W'($urandom_range(0, 1024)));
    endtask

    task automatic test_random_mix(input int count, input int setting);
        write_leftover(setting);
        run_random_items(count);
    endtask

    task automatic test_output_stall();
        hold_left = 300;
        run_random_items(14);
    endtask

    task automatic test_steady_stream();
        write_leftover(0);
        steady = 1'b1;
        run_random_items(150);
        steady = 1'b0;
    endtask

    // result side: random stalls plus a counted hold-off
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                rsp_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_beat.status = rsp_ch.status;
            got_beat.first  = rsp_ch.region_start;
            got_beat.last   = rsp_ch.region_end;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d start %0d end %0d",
                             got_beat.status, got_beat.first, got_beat.last);
            end
            else
            begin
                want_beat = pending_results.pop_front();
                if (got_beat.status !== want_beat.status || got_beat.first !== want_beat.first
                    || got_beat.last !== want_beat.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d start %0d end %0d",
                                 want_beat.status, want_beat.first, want_beat.last,
                                 ", got status %0d start %0d end %0d",
                                 got_beat.status, got_beat.first, got_beat.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < FREE_ENTRIES; i++)
        begin
            hole_first[i] = '0;
            hole_last[i]  = '0;
        end
        hole_last[0]   = ADDR_W'(MEM_SIZE - 1);
        hole_count     = 1;
        lease_count    = 0;
        leftover_limit = MIN_LEFTOVER_RST;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_ALLOC;
        req_ch.job_id       = '0;
        req_ch.request_size = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fill_tables();
        test_random_mix(220, 10);
        test_output_stall();
        test_random_mix(200, $urandom_range(1, 64));
        test_steady_stream();
        test_random_mix(30, 1024);

        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
